### hw/rtl/sparse_event_unpacker_unit_macros.svh
// Assertion helpers for the sparse event unpacker.
`ifndef SPARSE_EVENT_UNPACKER_UNIT_MACROS_SVH
`define SPARSE_EVENT_UNPACKER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SEU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("seu: check failed");
`define SEU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("seu: check failed");
`else
`define SEU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SEU_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/seu_pkg.sv
package seu_pkg;

    localparam int DEF_MAX_PARAMS = 256;
    localparam int TARGET_LIMIT   = 4096;
    localparam int MASK_WORD_BITS = 32;
    localparam int HEADER_LEN     = 6;

    localparam logic [1:0] FN_CLEAR  = 2'd0;
    localparam logic [1:0] FN_APPEND = 2'd1;
    localparam logic [1:0] FN_EVENT  = 2'd2;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_HEADER = 2'd1;
    localparam logic [1:0] ERR_EMPTY  = 2'd2;
    localparam logic [1:0] ERR_MASK   = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_MASK   = 4'b0100,
        PH_VALUE  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic clear;
        logic load;
        logic pop;
    } t_pend_ctl;

    // "event" followed by NUL
    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0: c = 8'h65;
            3'd1: c = 8'h76;
            3'd2: c = 8'h65;
            3'd3: c = 8'h6e;
            3'd4: c = 8'h74;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

### hw/rtl/seu_if.sv
interface seu_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic [7:0]         event_byte;
    logic               first_byte;
    logic signed [12:0] entry_target;

    modport source (output valid, func, event_byte, first_byte, entry_target, input ready);
    modport sink   (input valid, func, event_byte, first_byte, entry_target, output ready);
endinterface

interface seu_out_if;
    logic        valid;
    logic        ready;
    logic        has_value;
    logic [11:0] target_index;
    logic [63:0] value_bits;
    logic        event_done;
    logic [11:0] event_bytes;
    logic [1:0]  error_code;

    modport source (output valid, has_value, target_index, value_bits, event_done,
                    event_bytes, error_code, input ready);
    modport sink   (input valid, has_value, target_index, value_bits, event_done,
                    event_bytes, error_code, output ready);
endinterface

### hw/rtl/sparse_event_unpacker_unit.sv
// Sparse event unpacker: takes one item per clock unless the result register stalls, map
// writes and event bytes alike; each item is held in the input register and any result
// it gives in the result register; a full result register that is not taken holds the
// input register. The map sits in a single-port-read RAM whose address always follows
// the lowest pending mask bit, so the entry for the next value is read ahead while its
// eight bytes arrive. A mapped value is delivered on its eighth byte, errors and record
// ends on the byte that causes them. No clearing pass is needed after reset.
`include "sparse_event_unpacker_unit_macros.svh"

module sparse_event_unpacker_unit #(
    parameter int MAX_PARAMS = seu_pkg::DEF_MAX_PARAMS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    seu_in_if.sink     i_in,
    seu_out_if.source  o_out
);

    import seu_pkg::*;

    localparam int MASK_WORDS = (MAX_PARAMS + MASK_WORD_BITS - 1) / MASK_WORD_BITS;
    localparam int AW    = $clog2(MAX_PARAMS);
    localparam int CW    = $clog2(MAX_PARAMS + 1);
    localparam int MWW   = $clog2(MASK_WORDS + 1);
    localparam int MW_IW = (MASK_WORDS > 1) ? $clog2(MASK_WORDS) : 1;
    localparam int XW    = MWW + 6;

    // input register
    logic               r_iv;
    logic [1:0]         r_func;
    logic [7:0]         r_byte;
    logic               r_first;
    logic signed [12:0] r_tgt;

    // state
    t_phase        r_phase, n_phase;
    logic [2:0]    r_hp, n_hp;
    logic [2:0]    r_biw, n_biw;
    logic [MWW-1:0] r_mwi, n_mwi;
    logic [11:0]   r_bt, n_bt;
    logic [CW-1:0] r_count, n_count;
    logic [63:0]   r_word;

    // result register
    logic        r_ov;
    logic        r_o_hv;
    logic [11:0] r_o_tgt;
    logic [63:0] r_o_val;
    logic        r_o_done;
    logic [11:0] r_o_eb;
    logic [1:0]  r_o_err;

    logic        adv, in_rdy, busy, first;
    t_phase      e_phase;
    logic [2:0]  e_hp, e_biw;
    logic [11:0] e_bt;
    logic        wr_byte;
    logic        ram_we;
    t_pend_ctl   pctl, pctl_g;
    logic        res, res_hv, res_done;
    logic [1:0]  res_err;
    logic [63:0] res_val;
    logic [31:0] mword, okmask;
    logic [CW:0] nmask_sum, nmasks;
    logic [12:0] rd_tgt;
    logic        mapped;
    logic        pend_any, pend_multi;
    logic [AW-1:0] pend_lowest, pend_idx;

    assign adv    = r_iv && (!r_ov || o_out.ready);
    assign in_rdy = !r_iv || adv;
    assign i_in.ready = in_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (i_in.valid && in_rdy) begin
            r_iv <= 1'b1;
        end else if (adv) begin
            r_iv <= 1'b0;
        end
        if (i_in.valid && in_rdy) begin
            r_func  <= i_in.func;
            r_byte  <= i_in.event_byte;
            r_first <= i_in.first_byte;
            r_tgt   <= i_in.entry_target;
        end
    end

    seu_ram #(.WIDTH(13), .DEPTH(MAX_PARAMS)) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we && adv),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_tgt),
        .i_raddr (pend_lowest),
        .o_rdata (rd_tgt)
    );

    assign pctl_g = adv ? pctl : '0;

    seu_pend #(.MAX_PARAMS(MAX_PARAMS)) u_pend (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (pctl_g),
        .i_load_sel  (r_mwi[MW_IW-1:0]),
        .i_load_word (mword),
        .o_any       (pend_any),
        .o_lowest    (pend_lowest),
        .o_pidx      (pend_idx),
        .o_multi     (pend_multi)
    );

    always_comb begin
        mword     = {r_byte, r_word[23:0]};
        res_val   = {r_byte, r_word[55:0]};
        nmask_sum = {1'b0, r_count} + (CW+1)'(MASK_WORD_BITS - 1);
        nmasks    = nmask_sum >> 5;
        for (int b = 0; b < 32; b++) begin
            okmask[b] = (XW'({r_mwi, 5'b0}) + XW'(b)) < XW'(r_count);
        end
        mapped = !rd_tgt[12] && (17'(rd_tgt[11:0]) < 17'(TARGET_LIMIT));
    end

    always_comb begin
        busy    = (r_phase == PH_MASK) || (r_phase == PH_VALUE);
        first   = (r_func == FN_EVENT) && r_first;
        e_phase = first ? PH_HEADER : r_phase;
        e_hp    = first ? 3'd0 : r_hp;
        e_biw   = first ? 3'd0 : r_biw;
        e_bt    = first ? 12'd0 : r_bt;
        n_phase = r_phase;
        n_hp    = r_hp;
        n_biw   = r_biw;
        n_mwi   = r_mwi;
        n_bt    = r_bt;
        n_count = r_count;
        ram_we  = 1'b0;
        wr_byte = 1'b0;
        pctl    = '0;
        res     = 1'b0;
        res_hv  = 1'b0;
        res_done = 1'b0;
        res_err = ERR_NONE;
        case (r_func)
            FN_CLEAR: begin
                if (!busy) begin
                    n_count = '0;
                end
            end
            FN_APPEND: begin
                if (!busy && (r_count < CW'(MAX_PARAMS))) begin
                    ram_we  = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            FN_EVENT: begin
                if (first) begin
                    n_phase    = PH_HEADER;
                    n_hp       = '0;
                    n_biw      = '0;
                    n_mwi      = '0;
                    n_bt       = '0;
                    pctl.clear = 1'b1;
                end
                if (e_phase != PH_IDLE) begin
                    n_bt = e_bt + 12'd1;
                    case (e_phase)
                        PH_HEADER: begin
                            if ((e_hp >= 3'(HEADER_LEN)) || (r_byte != hdr_char(e_hp))) begin
                                n_phase  = PH_IDLE;
                                res      = 1'b1;
                                res_done = 1'b1;
                                res_err  = ERR_HEADER;
                            end else begin
                                n_hp = e_hp + 3'd1;
                                if (n_hp == 3'(HEADER_LEN)) begin
                                    if (r_count == '0) begin
                                        n_phase  = PH_IDLE;
                                        res      = 1'b1;
                                        res_done = 1'b1;
                                        res_err  = ERR_EMPTY;
                                    end else begin
                                        n_phase = PH_MASK;
                                    end
                                end
                            end
                        end
                        PH_MASK: begin
                            wr_byte = 1'b1;
                            n_biw   = e_biw + 3'd1;
                            if (e_biw == 3'd3) begin
                                n_biw = '0;
                                if (|(mword & ~okmask)) begin
                                    n_phase  = PH_IDLE;
                                    res      = 1'b1;
                                    res_done = 1'b1;
                                    res_err  = ERR_MASK;
                                end else begin
                                    pctl.load = 1'b1;
                                    n_mwi     = r_mwi + MWW'(1);
                                    if ((CW+1)'(n_mwi) >= nmasks) begin
                                        if (!pend_any && (mword == '0)) begin
                                            n_phase  = PH_IDLE;
                                            res      = 1'b1;
                                            res_done = 1'b1;
                                        end else begin
                                            n_phase = PH_VALUE;
                                        end
                                    end
                                end
                            end
                        end
                        PH_VALUE: begin
                            wr_byte = 1'b1;
                            n_biw   = e_biw + 3'd1;
                            if (e_biw == 3'd7) begin
                                pctl.pop = 1'b1;
                                if (!pend_multi) begin
                                    n_phase = PH_IDLE;
                                end
                                if (mapped || !pend_multi) begin
                                    res      = 1'b1;
                                    res_hv   = mapped;
                                    res_done = !pend_multi;
                                end
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_hp    <= '0;
            r_biw   <= '0;
            r_mwi   <= '0;
            r_bt    <= '0;
            r_count <= '0;
        end else if (adv) begin
            r_phase <= n_phase;
            r_hp    <= n_hp;
            r_biw   <= n_biw;
            r_mwi   <= n_mwi;
            r_bt    <= n_bt;
            r_count <= n_count;
        end
        if (adv && wr_byte) begin
            r_word[{e_biw, 3'b000} +: 8] <= r_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv && res) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
        if (adv && res) begin
            r_o_hv   <= res_hv;
            r_o_tgt  <= res_hv ? rd_tgt[11:0] : 12'd0;
            r_o_val  <= res_hv ? res_val : 64'd0;
            r_o_done <= res_done;
            r_o_eb   <= res_done ? n_bt : 12'd0;
            r_o_err  <= res_err;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.has_value    = r_o_hv;
    assign o_out.target_index = r_o_tgt;
    assign o_out.value_bits   = r_o_val;
    assign o_out.event_done   = r_o_done;
    assign o_out.event_bytes  = r_o_eb;
    assign o_out.error_code   = r_o_err;

    `SEU_ASSERT_IMP(a_value_has_pending, i_clk, i_rst_n, r_phase == PH_VALUE, pend_any)
    `SEU_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, r_iv || !r_iv, r_count <= CW'(MAX_PARAMS))
    `SEU_ASSERT_IMP(a_pop_within_map, i_clk, i_rst_n, pctl_g.pop, CW'(pend_idx) < r_count)
    `SEU_ASSERT_IMP(a_error_ends_record, i_clk, i_rst_n, r_ov && (r_o_err != ERR_NONE),
                    r_o_done && !r_o_hv)
    `SEU_ASSERT_NXT(a_map_frozen, i_clk, i_rst_n, busy && adv && (r_func != FN_EVENT),
                    $stable(r_count))

endmodule

### hw/rtl/seu_ram.sv
module seu_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/seu_pend.sv
module seu_pend #(
    parameter int MAX_PARAMS = seu_pkg::DEF_MAX_PARAMS,
    localparam int MASK_WORDS = (MAX_PARAMS + seu_pkg::MASK_WORD_BITS - 1)
                                / seu_pkg::MASK_WORD_BITS,
    localparam int PW    = MASK_WORDS * seu_pkg::MASK_WORD_BITS,
    localparam int AW    = $clog2(MAX_PARAMS),
    localparam int MW_IW = (MASK_WORDS > 1) ? $clog2(MASK_WORDS) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  seu_pkg::t_pend_ctl  i_ctl,
    input  logic [MW_IW-1:0]    i_load_sel,
    input  logic [31:0]         i_load_word,
    output logic                o_any,
    output logic [AW-1:0]       o_lowest,
    output logic [AW-1:0]       o_pidx,
    output logic                o_multi
);

    import seu_pkg::*;

    logic [PW-1:0] r_pend;
    logic [PW-1:0] n_pend;
    logic [AW-1:0] r_pidx;
    logic          r_multi;

    logic [31:0]   words [32];
    logic [31:0]   wfound;
    logic [4:0]    wsel;
    logic [31:0]   sword;
    logic [4:0]    bsel;
    logic          multi;

    // lowest set bit by halving, five steps
    function automatic logic [4:0] f_lowest(input logic [31:0] w);
        logic [31:0] v;
        logic [4:0]  idx;
        v   = w;
        idx = '0;
        for (int s = 4; s >= 0; s--) begin
            if ((v & ((32'd1 << (1 << s)) - 32'd1)) == 32'd0) begin
                idx[s] = 1'b1;
                v      = v >> (1 << s);
            end
        end
        return idx;
    endfunction

    always_comb begin
        for (int k = 0; k < 32; k++) begin
            words[k]  = '0;
            wfound[k] = 1'b0;
        end
        for (int k = 0; k < MASK_WORDS; k++) begin
            words[k]  = r_pend[k*32 +: 32];
            wfound[k] = |r_pend[k*32 +: 32];
        end
        wsel  = f_lowest(wfound);
        sword = words[wsel];
        bsel  = f_lowest(sword);
        multi = (|(wfound & ~(32'd1 << wsel))) || (|(sword & (sword - 32'd1)));
    end

    assign o_lowest = AW'({wsel, bsel});

    always_comb begin
        n_pend = r_pend;
        if (i_ctl.clear) begin
            n_pend = '0;
        end else if (i_ctl.load) begin
            for (int k = 0; k < MASK_WORDS; k++) begin
                if (i_load_sel == MW_IW'(k)) begin
                    n_pend[k*32 +: 32] = i_load_word;
                end
            end
        end else if (i_ctl.pop) begin
            n_pend = r_pend & ~(PW'(1) << r_pidx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
        r_pidx  <= o_lowest;
        r_multi <= multi;
    end

    assign o_any   = |r_pend;
    assign o_pidx  = r_pidx;
    assign o_multi = r_multi;

endmodule

### verif/sparse_event_unpacker_unit_tb.sv
module sparse_event_unpacker_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import seu_pkg::*;

    localparam int MAXP        = DEF_MAX_PARAMS;
    localparam int N_ITEMS     = 1800;
    localparam int WATCHDOG    = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [1:0]  FN_UNUSED = 2'd3;
    // "event" and NUL, first character in the low byte
    localparam logic [47:0] EVENT_TAG = 48'h00_74_6e_65_76_65;

    typedef enum int {PACE_FULL, PACE_SPREAD, PACE_BURSTY} pace_t;

    typedef struct {
        logic [1:0]         func;
        logic [7:0]         ev_byte;
        logic               first;
        logic signed [12:0] target;
        bit                 drain_first;
    } seu_item_t;

    typedef struct {
        logic        has_value;
        logic [11:0] target_index;
        logic [63:0] value_bits;
        logic        event_done;
        logic [11:0] event_bytes;
        logic [1:0]  error_code;
    } seu_result_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    seu_in_if  in_if ();
    seu_out_if out_if ();

    sparse_event_unpacker_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // unpacker state as predicted
    logic signed [12:0] map_tgt [MAXP];
    int unsigned        map_len;
    t_phase             rec_phase;
    int unsigned        hdr_pos;
    logic [63:0]        asm_word;
    int unsigned        asm_cnt;
    logic [MAXP-1:0]    pend_mask;
    int unsigned        mask_idx;
    logic [11:0]        rec_len;
    seu_result_t        due_results [$];

    seu_item_t stim_q [$];
    seu_item_t rec_q [$];
    int        plan_len;
    int        live_items;
    int        next_drain;
    bit        drain_next;

    int    items_in    = 0;
    int    fails       = 0;
    int    n_results   = 0;
    int    n_values    = 0;
    int    n_done      = 0;
    int    n_err [4]   = '{0, 0, 0, 0};
    int    idle_cycles = 0;
    logic  rx_hold     = 1'b0;

    function automatic void queue_result(logic hv, logic [11:0] tgt, logic [63:0] val,
                                         logic done, logic [1:0] err);
        seu_result_t r;
        r.has_value    = hv;
        r.target_index = hv ? tgt : 12'd0;
        r.value_bits   = hv ? val : 64'd0;
        r.event_done   = done;
        r.event_bytes  = done ? rec_len : 12'd0;
        r.error_code   = err;
        due_results = {due_results, r};
    endfunction

    function automatic void unpack_byte(logic [7:0] b, logic first);
        logic [31:0]        w;
        logic [63:0]        val;
        logic signed [12:0] t;
        int unsigned        idx;
        int unsigned        nmasks;
        bit                 bad;
        bit                 found;
        bit                 mapped;
        bit                 more;
        if (first) begin
            rec_phase = PH_HEADER;
            hdr_pos   = 0;
            rec_len   = '0;
            asm_word  = '0;
            asm_cnt   = 0;
            mask_idx  = 0;
            pend_mask = '0;
        end
        if (rec_phase == PH_IDLE) return;
        rec_len = rec_len + 12'd1;
        case (rec_phase)
            PH_HEADER: begin
                if (b != EVENT_TAG[8*hdr_pos +: 8]) begin
                    rec_phase = PH_IDLE;
                    queue_result(1'b0, 12'd0, 64'd0, 1'b1, ERR_HEADER);
                end else begin
                    hdr_pos++;
                    if (hdr_pos == HEADER_LEN) begin
                        if (map_len == 0) begin
                            rec_phase = PH_IDLE;
                            queue_result(1'b0, 12'd0, 64'd0, 1'b1, ERR_EMPTY);
                        end else begin
                            rec_phase = PH_MASK;
                        end
                    end
                end
            end
            PH_MASK: begin
                asm_word[8*asm_cnt +: 8] = b;
                asm_cnt++;
                if (asm_cnt == 4) begin
                    w        = asm_word[31:0];
                    asm_word = '0;
                    asm_cnt  = 0;
                    bad      = 1'b0;
                    for (int i = 0; i < MASK_WORD_BITS; i++)
                        if (w[i] && mask_idx * MASK_WORD_BITS + i >= map_len) bad = 1'b1;
                    if (bad) begin
                        rec_phase = PH_IDLE;
                        queue_result(1'b0, 12'd0, 64'd0, 1'b1, ERR_MASK);
                    end else begin
                        pend_mask[mask_idx*MASK_WORD_BITS +: MASK_WORD_BITS] = w;
                        mask_idx++;
                        nmasks = (map_len + MASK_WORD_BITS - 1) / MASK_WORD_BITS;
                        if (mask_idx >= nmasks) begin
                            if (pend_mask == '0) begin
                                rec_phase = PH_IDLE;
                                queue_result(1'b0, 12'd0, 64'd0, 1'b1, ERR_NONE);
                            end else begin
                                rec_phase = PH_VALUE;
                            end
                        end
                    end
                end
            end
            default: begin
                asm_word[8*asm_cnt +: 8] = b;
                asm_cnt++;
                if (asm_cnt == 8) begin
                    val      = asm_word;
                    asm_word = '0;
                    asm_cnt  = 0;
                    found    = 1'b0;
                    idx      = 0;
                    for (int i = 0; i < MAXP; i++)
                        if (!found && pend_mask[i]) begin
                            found = 1'b1;
                            idx   = i;
                        end
                    if (found) pend_mask[idx] = 1'b0;
                    t = -13'sd1;
                    if (found && idx < map_len) t = map_tgt[idx];
                    mapped = found && !t[12];
                    more   = (pend_mask != '0);
                    if (!more) rec_phase = PH_IDLE;
                    if (mapped || !more) queue_result(mapped, t[11:0], val, !more, ERR_NONE);
                end
            end
        endcase
    endfunction

    function automatic void unpack_item(seu_item_t it);
        bit busy;
        busy = (rec_phase == PH_MASK) || (rec_phase == PH_VALUE);
        case (it.func)
            FN_CLEAR: begin
                if (!busy) map_len = 0;
            end
            FN_APPEND: begin
                if (!busy && map_len < MAXP) begin
                    map_tgt[map_len] = it.target;
                    map_len++;
                end
            end
            FN_EVENT: unpack_byte(it.ev_byte, it.first);
            default: ;
        endcase
    endfunction

    function automatic int pick_wait(inout pace_t mode, inout int left);
        if (left <= 0) begin
            mode = pace_t'($urandom_range(0, 2));
            left = $urandom_range(16, 96);
        end
        left--;
        if (mode == PACE_FULL) return 0;
        if (mode == PACE_SPREAD) return $urandom_range(0, 15);
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
    endfunction

    // stimulus building
    function automatic seu_item_t make_item(logic [1:0] func);
        seu_item_t it;
        it.func        = func;
        it.ev_byte     = 8'($urandom);
        it.first       = 1'($urandom);
        it.target      = 13'($urandom);
        it.drain_first = 1'b0;
        return it;
    endfunction

    function automatic seu_item_t byte_item(logic [7:0] b, logic first);
        seu_item_t it;
        it         = make_item(FN_EVENT);
        it.ev_byte = b;
        it.first   = first;
        return it;
    endfunction

    function automatic seu_item_t map_item(logic [1:0] func, logic signed [12:0] tgt);
        seu_item_t it;
        it        = make_item(func);
        it.target = tgt;
        return it;
    endfunction

    function automatic void add_item(seu_item_t it);
        if (drain_next) begin
            it.drain_first = 1'b1;
            drain_next     = 1'b0;
        end
        stim_q = {stim_q, it};
        live_items++;
    endfunction

    function automatic void flush_rec(int n);
        for (int i = 0; i < n; i++) add_item(rec_q[i]);
        rec_q.delete();
    endfunction

    function automatic void rec_header(int n);
        for (int p = 0; p < n; p++) rec_q = {rec_q, byte_item(EVENT_TAG[8*p +: 8], p == 0)};
    endfunction

    function automatic void rec_word(logic [63:0] v, int nbytes);
        for (int k = 0; k < nbytes; k++) rec_q = {rec_q, byte_item(v[8*k +: 8], 1'b0)};
    endfunction

    // ignored func code or stray bytes while idle
    function automatic void add_noise();
        int n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
            if ($urandom_range(0, 1)) stim_q = {stim_q, make_item(FN_UNUSED)};
            else stim_q = {stim_q, byte_item(8'($urandom), 1'b0)};
    endfunction

    function automatic logic signed [12:0] rand_target();
        case ($urandom_range(0, 7))
            0: return -13'sd1;
            1: return 13'h0FFF;
            2: return 13'h1000;
            3: return 13'h0000;
            4: return 13'($urandom);
            default: return 13'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic logic [MAXP-1:0] pick_bits();
        logic [MAXP-1:0] bits;
        int              den;
        bits = '0;
        case ($urandom_range(0, 5))
            0: den = 0;
            1: den = 1;
            2, 3: den = 2;
            default: den = 8;
        endcase
        if (plan_len > 40 && den != 0 && den < 8) den = 16;
        for (int i = 0; i < plan_len; i++)
            if (den != 0 && $urandom_range(0, den - 1) == 0) bits[i] = 1'b1;
        return bits;
    endfunction

    function automatic void gen_map();
        int k;
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) k = MAXP;
        else if (r < 24) k = $urandom_range(33, 96);
        else k = $urandom_range(1, 32);
        if (plan_len + k > MAXP || $urandom_range(0, 2) != 0) begin
            add_item(map_item(FN_CLEAR, rand_target()));
            plan_len = 0;
        end
        for (int i = 0; i < k; i++) begin
            add_item(map_item(FN_APPEND, rand_target()));
            plan_len++;
        end
        // append into a full map
        if (plan_len == MAXP) add_item(map_item(FN_APPEND, rand_target()));
    endfunction

    function automatic void gen_record(bit abandon, bit meddle);
        logic [MAXP-1:0] bits;
        int              nm;
        int              pos;
        bits = pick_bits();
        nm   = (plan_len + MASK_WORD_BITS - 1) / MASK_WORD_BITS;
        rec_header(HEADER_LEN);
        for (int w = 0; w < nm; w++) rec_word(bits[w*MASK_WORD_BITS +: MASK_WORD_BITS], 4);
        for (int i = 0; i < plan_len; i++)
            if (bits[i])
                case ($urandom_range(0, 7))
                    0: rec_word('0, 8);
                    1: rec_word('1, 8);
                    default: rec_word({$urandom, $urandom}, 8);
                endcase
        // map write inside the mask or value part, to be ignored
        if (meddle) begin
            pos = $urandom_range(HEADER_LEN, rec_q.size() - 1);
            rec_q.insert(pos, map_item($urandom_range(0, 1) ? FN_CLEAR : FN_APPEND,
                                       rand_target()));
        end
        flush_rec(abandon ? $urandom_range(1, rec_q.size() - 1) : rec_q.size());
    endfunction

    function automatic void gen_mask_error();
        logic [MAXP-1:0] bits;
        int              nm;
        int              idx;
        bits = pick_bits();
        nm   = (plan_len + MASK_WORD_BITS - 1) / MASK_WORD_BITS;
        idx  = (nm - 1) * MASK_WORD_BITS
             + $urandom_range(plan_len % MASK_WORD_BITS, MASK_WORD_BITS - 1);
        bits[idx] = 1'b1;
        rec_header(HEADER_LEN);
        for (int w = 0; w < nm; w++) rec_word(bits[w*MASK_WORD_BITS +: MASK_WORD_BITS], 4);
        flush_rec(rec_q.size());
        add_noise();
    endfunction

    function automatic void gen_header_error();
        int         p;
        logic [7:0] b;
        p = $urandom_range(0, HEADER_LEN - 1);
        rec_header(p);
        do b = 8'($urandom); while (b == EVENT_TAG[8*p +: 8]);
        rec_q = {rec_q, byte_item(b, p == 0)};
        flush_rec(rec_q.size());
        add_noise();
    endfunction

    function automatic void gen_empty();
        add_item(map_item(FN_CLEAR, rand_target()));
        plan_len = 0;
        rec_header(HEADER_LEN);
        rec_word({$urandom, $urandom}, $urandom_range(0, 4));
        flush_rec(rec_q.size());
    endfunction

    // driver
    seu_item_t drv_item;
    int        drv_gap  = 0;
    pace_t     drv_mode = PACE_FULL;
    int        drv_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            drv_gap = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                unpack_item(drv_item);
                items_in++;
                drv_gap = pick_wait(drv_mode, drv_left);
            end
            if (!in_if.valid || in_if.ready) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    in_if.valid <= 1'b0;
                end else if (stim_q.size() != 0 &&
                             !(stim_q[0].drain_first && due_results.size() != 0)) begin
                    drv_item = stim_q.pop_front();
                    in_if.valid        <= 1'b1;
                    in_if.func         <= drv_item.func;
                    in_if.event_byte   <= drv_item.ev_byte;
                    in_if.first_byte   <= drv_item.first;
                    in_if.entry_target <= drv_item.target;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int    rx_wait = 0;
    pace_t rx_mode = PACE_FULL;
    int    rx_left = 0;

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
            fails++;
        end
    endfunction

    function automatic void compare_result();
        seu_result_t want;
        if (due_results.size() == 0) begin
            $error("result with none due: has_value %0b event_done %0b error_code %0d",
                   out_if.has_value, out_if.event_done, out_if.error_code);
            fails++;
            return;
        end
        want = due_results.pop_front();
        n_results++;
        if (want.has_value) n_values++;
        if (want.event_done) n_done++;
        n_err[want.error_code]++;
        check_field("has_value", want.has_value, out_if.has_value);
        check_field("target_index", want.target_index, out_if.target_index);
        check_field("value_bits", want.value_bits, out_if.value_bits);
        check_field("event_done", want.event_done, out_if.event_done);
        check_field("event_bytes", want.event_bytes, out_if.event_bytes);
        check_field("error_code", want.error_code, out_if.error_code);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                compare_result();
                rx_wait = pick_wait(rx_mode, rx_left);
            end
            if (rx_hold) begin
                out_if.ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // long receiver stall so the input side backs up
    initial begin
        while (items_in < 400) @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < WATCHDOG) @(posedge i_clk);
        $display("watchdog: nothing accepted for %0d cycles", WATCHDOG);
        $display("status: fail");
        $finish;
    end

    initial begin
        int r;
        bit abandon;
        in_if.valid        = 1'b0;
        in_if.func         = FN_CLEAR;
        in_if.event_byte   = '0;
        in_if.first_byte   = 1'b0;
        in_if.entry_target = '0;
        out_if.ready       = 1'b0;

        map_len    = 0;
        rec_phase  = PH_IDLE;
        hdr_pos    = 0;
        asm_word   = '0;
        asm_cnt    = 0;
        pend_mask  = '0;
        mask_idx   = 0;
        rec_len    = '0;
        plan_len   = 0;
        live_items = 0;
        next_drain = 900;
        drain_next = 1'b0;

        // directed: bad second header byte, empty map, lone unmapped value
        rec_q = {rec_q, byte_item(EVENT_TAG[7:0], 1'b1)};
        rec_q = {rec_q, byte_item(8'hff, 1'b0)};
        rec_header(HEADER_LEN);
        flush_rec(rec_q.size());
        add_item(map_item(FN_APPEND, -13'sd1));
        plan_len = 1;
        rec_header(HEADER_LEN);
        rec_word(64'd1, 4);
        rec_word('1, 8);
        flush_rec(rec_q.size());

        while (live_items < N_ITEMS) begin
            if (live_items >= next_drain) begin
                drain_next = 1'b1;
                next_drain += 700;
            end
            r = $urandom_range(0, 99);
            if (plan_len == 0 || r < 10) begin
                gen_map();
            end else if (r < 16) begin
                add_noise();
            end else if (r < 24) begin
                gen_header_error();
            end else if (r < 28) begin
                gen_empty();
            end else if (r < 38 && plan_len % MASK_WORD_BITS != 0) begin
                gen_mask_error();
            end else begin
                abandon = ($urandom_range(0, 7) == 0);
                gen_record(abandon, $urandom_range(0, 5) == 0);
                // restart inside the abandoned record
                if (abandon) gen_record(1'b0, 1'b0);
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() != 0 || in_if.valid) @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("summary: %0d items in, %0d results checked (%0d values, %0d record ends)",
                 items_in, n_results, n_values, n_done);
        $display("summary: errors seen - header %0d, empty map %0d, mask bit %0d",
                 n_err[ERR_HEADER], n_err[ERR_EMPTY], n_err[ERR_MASK]);
        if (fails == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/seu_pkg.sv
hw/rtl/seu_if.sv
hw/rtl/seu_ram.sv
hw/rtl/seu_pend.sv
hw/rtl/sparse_event_unpacker_unit.sv
verif/sparse_event_unpacker_unit_tb.sv
